// File: rtl/krle_pkg.sv
// ----------------------------------------------------------------------------
// krle_pkg
// Shared types and constants for the key ripple light engine.
// ----------------------------------------------------------------------------
package krle_pkg;

  localparam int CNT_W = 7;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PRESS = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_SHOW    = 2'd1;
  localparam logic [1:0] ACT_RESTORE = 2'd2;

  localparam logic [7:0]  TRAVEL_PIXELS = 8'd240;
  localparam logic [9:0]  TRAVEL_MS     = 10'd900;
  localparam logic [8:0]  BAND_PIXELS   = 9'd26;
  localparam logic [31:0] RADIUS_LIMIT  = 32'd266;
  localparam logic [8:0]  HUE_STEP      = 9'd73;
  localparam logic [9:0]  HUE_WRAP      = 10'd360;
  localparam logic [7:0]  IDLE_OPACITY  = 8'd153;

  // strength = 100 - delta*100/26 for delta 0..25
  localparam logic [6:0] STRENGTH_LUT [26] = '{
    7'd100, 7'd97, 7'd93, 7'd89, 7'd85, 7'd81, 7'd77, 7'd74, 7'd70, 7'd66,
    7'd62,  7'd58, 7'd54, 7'd50, 7'd47, 7'd43, 7'd39, 7'd35, 7'd31, 7'd27,
    7'd24,  7'd20, 7'd16, 7'd12, 7'd8,  7'd4
  };

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  key_sel;
    logic [7:0]  pos_x;
    logic [6:0]  pos_y;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [5:0] out_key;
    logic [1:0] action;
    logic [8:0] hue;
    logic [7:0] opacity;
    logic       frame_live;
    logic       last;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_PRESS,
    OP_FRAME
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  key_sel;
    logic [7:0]  pos_x;
    logic [6:0]  pos_y;
    logic [31:0] now_ms;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAIM,
    ST_PRE,
    ST_DIV,
    ST_KRD,
    ST_KSLOT,
    ST_KOUT
  } back_state_t;

endpackage

// File: rtl/krle_front.sv
// ----------------------------------------------------------------------------
// krle_front
// Accepts items, classifies them into work ops and queues them for the back.
// ----------------------------------------------------------------------------
module krle_front import krle_pkg::*; #(
  parameter int MAX_KEYS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  input  logic [CNT_W-1:0] eff_count,
  output logic             q_valid,
  input  logic             q_pop,
  output work_t            q_head
);

  work_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  work_t      cls;
  logic       push;

  // classify the incoming item
  always_comb begin
    cls.key_sel = req.key_sel;
    cls.pos_x   = req.pos_x;
    cls.pos_y   = req.pos_y;
    cls.now_ms  = req.now_ms;
    cls.op      = OP_NOP;
    case (req.command)
      CMD_LOAD:  if ({1'b0, req.key_sel} < CNT_W'(MAX_KEYS)) cls.op = OP_LOAD;
      CMD_PRESS: if ({1'b0, req.key_sel} < eff_count) cls.op = OP_PRESS;
      CMD_TICK:  if (eff_count != '0) cls.op = OP_FRAME;
      default:   cls.op = OP_NOP;
    endcase
  end

  assign req_ready = (fill != 2'd2);
  assign push      = req_valid && req_ready;
  assign q_valid   = (fill != 2'd0);
  assign q_head    = entry[rd_ptr];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// File: rtl/krle_div.sv
// ----------------------------------------------------------------------------
// krle_div
// Ring radius: travel in pixel-ms divided by the ring travel time.
// ----------------------------------------------------------------------------
module krle_div import krle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  output logic        done,
  output logic [31:0] quotient
);

  // travel at or above this gives a radius past the limit
  localparam logic [31:0] EXPIRE_AT = (RADIUS_LIMIT + 32'd1) * 32'(TRAVEL_MS);
  // 900 = 4 * 225; ceil(2^32 / 225) is exact for every quarter below EXPIRE_AT / 4
  localparam logic [24:0] RECIP_225 = 25'd19088744;

  logic [31:0] held;
  logic        busy;
  logic [40:0] prod;

  assign prod = 41'(held[17:2]) * 41'(RECIP_225);

  // capture, then reciprocal multiply
  always_ff @(posedge clk) begin
    if (start) held <= dividend;
    if (busy) begin
      if (held >= EXPIRE_AT) quotient <= RADIUS_LIMIT + 32'd1;
      else                   quotient <= {23'd0, prod[40:32]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

endmodule

// File: rtl/krle_back.sv
// ----------------------------------------------------------------------------
// krle_back
// Executes queued ops: centre loads, slot claims and frame rendering.
// ----------------------------------------------------------------------------
module krle_back import krle_pkg::*; #(
  parameter int MAX_KEYS     = 64,
  parameter int RIPPLE_SLOTS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] eff_count,
  input  logic             q_valid,
  output logic             q_pop,
  input  work_t            q_head,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int SW = (RIPPLE_SLOTS > 1) ? $clog2(RIPPLE_SLOTS) : 1;

  back_state_t state, state_next;
  work_t       cur;

  // slot state
  logic [RIPPLE_SLOTS-1:0] active;
  logic [RIPPLE_SLOTS-1:0] live;
  logic [31:0] start_time [RIPPLE_SLOTS];
  logic [8:0]  slot_hue   [RIPPLE_SLOTS];
  logic [5:0]  origin     [RIPPLE_SLOTS];
  logic [8:0]  radius     [RIPPLE_SLOTS];
  logic [7:0]  org_x      [RIPPLE_SLOTS];
  logic [6:0]  org_y      [RIPPLE_SLOTS];
  logic [8:0]  hue_counter;

  // key centres and lit flags
  logic [14:0]         centre_mem [MAX_KEYS];
  logic [14:0]         rd_data;
  logic [KW-1:0]       rd_addr;
  logic [MAX_KEYS-1:0] lit;

  logic [SW-1:0] s;
  logic [KW-1:0] k;
  logic [SW-1:0] pick, pick_c;
  logic          found, found_c;
  logic          any;
  logic [6:0]    strongest;
  logic [8:0]    khue;
  logic          s_last, k_last, out_free;

  logic        div_start, div_done;
  logic [31:0] div_quo;
  logic [31:0] age_s, age_p;
  logic [31:0] travel;

  assign s_last   = (s == SW'(RIPPLE_SLOTS - 1));
  assign k_last   = ((CNT_W'(k) + CNT_W'(1)) == eff_count);
  assign out_free = !rsp_valid || rsp_ready;
  assign age_s    = cur.now_ms - start_time[s];
  assign age_p    = cur.now_ms - start_time[pick];
  assign travel   = age_s * 32'(TRAVEL_PIXELS);

  krle_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (travel),
    .done     (div_done),
    .quotient (div_quo)
  );

  // slot choice: first inactive, otherwise the oldest
  always_comb begin
    pick_c  = pick;
    found_c = found;
    if (!found) begin
      if (!active[s]) begin
        pick_c  = s;
        found_c = 1'b1;
      end else if (age_s > age_p) begin
        pick_c = s;
      end
    end
  end

  // distance from the current slot's origin to the current key
  logic [7:0]  dx, big;
  logic [6:0]  dy, small_v;
  logic [8:0]  ring_dist, delta;
  logic [9:0]  hsum, hsub1;
  logic [8:0]  hmod;
  logic [6:0]  str;
  logic        in_band;

  always_comb begin
    dx        = (org_x[s] > rd_data[14:7]) ? org_x[s] - rd_data[14:7]
                                           : rd_data[14:7] - org_x[s];
    dy        = (org_y[s] > rd_data[6:0]) ? org_y[s] - rd_data[6:0]
                                          : rd_data[6:0] - org_y[s];
    big       = (dx > {1'b0, dy}) ? dx : {1'b0, dy};
    small_v   = (dx > {1'b0, dy}) ? dy : dx[6:0];
    ring_dist = {1'b0, big} + {3'b000, small_v[6:1]};
    delta     = (ring_dist > radius[s]) ? ring_dist - radius[s] : radius[s] - ring_dist;
    in_band   = live[s] && (delta < BAND_PIXELS);
    str       = in_band ? STRENGTH_LUT[delta[4:0]] : 7'd0;
    hsum      = {1'b0, slot_hue[s]} + {ring_dist, 1'b0};
    hsub1     = (hsum >= HUE_WRAP) ? hsum - HUE_WRAP : hsum;
    hmod      = (hsub1 >= HUE_WRAP) ? 9'(hsub1 - HUE_WRAP) : hsub1[8:0];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_head.op)
            OP_PRESS: state_next = ST_CLAIM;
            OP_FRAME: state_next = ST_PRE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLAIM: if (s_last) state_next = ST_PRE;
      ST_PRE: begin
        if (active[s]) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else if (s_last) begin
          state_next = ST_KRD;
        end
      end
      ST_DIV:   if (div_done) state_next = s_last ? ST_KRD : ST_PRE;
      ST_KRD:   state_next = ST_KSLOT;
      ST_KSLOT: if (s_last) state_next = ST_KOUT;
      ST_KOUT:  if (out_free) state_next = k_last ? ST_IDLE : ST_KRD;
      default:  state_next = ST_IDLE;
    endcase
  end

  // centre memory: one write, one registered read
  always_comb begin
    if (state == ST_PRE || state == ST_DIV) rd_addr = origin[s][KW-1:0];
    else                                    rd_addr = k;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_head.op == OP_LOAD)
      centre_mem[q_head.key_sel[KW-1:0]] <= {q_head.pos_x, q_head.pos_y};
    rd_data <= centre_mem[rd_addr];
  end

  // result fields for the current key
  rsp_t res;
  always_comb begin
    res.out_key    = 6'(k);
    res.frame_live = any;
    res.last       = k_last;
    if (strongest != 7'd0) begin
      res.action  = ACT_SHOW;
      res.hue     = khue;
      res.opacity = IDLE_OPACITY + {1'b0, strongest}
                    + ((strongest >= 7'd100) ? 8'd2 : (strongest >= 7'd50) ? 8'd1 : 8'd0);
    end else if (lit[k]) begin
      res.action  = ACT_RESTORE;
      res.hue     = '0;
      res.opacity = IDLE_OPACITY;
    end else begin
      res.action  = ACT_NONE;
      res.hue     = '0;
      res.opacity = '0;
    end
  end

  // slot and frame datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= '0;
      live        <= '0;
      lit         <= '0;
      hue_counter <= '0;
      s           <= '0;
      k           <= '0;
      pick        <= '0;
      found       <= 1'b0;
      any         <= 1'b0;
      strongest   <= '0;
      khue        <= '0;
      for (int i = 0; i < RIPPLE_SLOTS; i++) begin
        start_time[i] <= '0;
        slot_hue[i]   <= '0;
        origin[i]     <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          s     <= '0;
          k     <= '0;
          pick  <= '0;
          found <= 1'b0;
          any   <= 1'b0;
          if (q_valid) begin
            cur <= q_head;
            if (q_head.op == OP_LOAD) lit[q_head.key_sel[KW-1:0]] <= 1'b0;
          end
        end
        ST_CLAIM: begin
          pick  <= pick_c;
          found <= found_c;
          if (s_last) begin
            s                  <= '0;
            start_time[pick_c] <= cur.now_ms;
            slot_hue[pick_c]   <= hue_counter;
            origin[pick_c]     <= cur.key_sel;
            active[pick_c]     <= 1'b1;
            hue_counter <= ({1'b0, hue_counter} + {1'b0, HUE_STEP} >= HUE_WRAP)
                           ? 9'({1'b0, hue_counter} + {1'b0, HUE_STEP} - HUE_WRAP)
                           : hue_counter + HUE_STEP;
          end else begin
            s <= s + SW'(1);
          end
        end
        ST_PRE: begin
          if (!active[s]) begin
            live[s] <= 1'b0;
            s       <= s_last ? '0 : s + SW'(1);
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (div_quo > RADIUS_LIMIT) begin
              active[s] <= 1'b0;
              live[s]   <= 1'b0;
            end else begin
              live[s]   <= 1'b1;
              radius[s] <= div_quo[8:0];
              org_x[s]  <= rd_data[14:7];
              org_y[s]  <= rd_data[6:0];
              any       <= 1'b1;
            end
            s <= s_last ? '0 : s + SW'(1);
          end
        end
        ST_KRD: begin
          s         <= '0;
          strongest <= '0;
          khue      <= '0;
        end
        ST_KSLOT: begin
          if (str > strongest) begin
            strongest <= str;
            khue      <= hmod;
          end
          s <= s_last ? '0 : s + SW'(1);
        end
        ST_KOUT: begin
          if (out_free) begin
            lit[k] <= (strongest != 7'd0);
            k      <= k + KW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_KOUT && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_KOUT && out_free) rsp <= res;
  end

  // checks
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.hue < 9'd360))
    else $error("result hue out of range");

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    hue_counter < 9'd360)
    else $error("hue counter out of range");

  a_show_opacity: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.action == ACT_SHOW) |-> (rsp.opacity >= IDLE_OPACITY))
    else $error("shown key below idle opacity");

  a_live_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KSLOT) |-> ((live & ~active) == '0))
    else $error("live slot not active during key pass");

  a_div_only_pre: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == ST_DIV))
    else $error("divider started outside slot pass");

endmodule

// File: rtl/key_ripple_light_engine_core.sv
// ----------------------------------------------------------------------------
// key_ripple_light_engine_core
// Ripple lighting engine: key centre table, ripple slots, per-key frame output.
// ----------------------------------------------------------------------------
//  channel  | signals                      | moves
//  ---------+------------------------------+-------------------------------
//  req      | req_valid, req_ready, req    | load / press / tick item
//  rsp      | rsp_valid, rsp_ready, rsp    | one item per key of a frame
//  cfg      | cfg_we, cfg_wdata            | layout size register
//
//  A load retires straight from the back end's idle state. A frame first
//  turns every active slot's age into a radius through the reciprocal
//  divider (idle slots are skipped), then walks the keys, visiting every
//  slot for each key; a press first scans every slot to claim one.
//  Reset (rst, synchronous) clears slots, lit flags and the hue counter.
//  A two-entry queue takes items while the back is busy, until it is
//  full; a stalled rsp holds the key walk.
// ----------------------------------------------------------------------------
module key_ripple_light_engine_core import krle_pkg::*; #(
  parameter int MAX_KEYS     = 64,
  parameter int RIPPLE_SLOTS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0] layout_size;
  logic [CNT_W-1:0] eff_count;
  logic             q_valid;
  logic             q_pop;
  work_t            q_head;

  // layout size register; its effective count is clamped to the table depth
  always_ff @(posedge clk) begin
    if (rst)         layout_size <= '0;
    else if (cfg_we) layout_size <= cfg_wdata;
  end

  assign eff_count = (layout_size > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : layout_size;

  krle_front #(.MAX_KEYS(MAX_KEYS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .eff_count (eff_count),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  krle_back #(.MAX_KEYS(MAX_KEYS), .RIPPLE_SLOTS(RIPPLE_SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .eff_count (eff_count),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: test/krle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// krle_checker
// Watches the request, response and config ports of the ripple engine,
// predicts every per-key frame item and compares each response in order.
// ----------------------------------------------------------------------------
module krle_checker import krle_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_ready,
  input  req_t             req,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);

  localparam int KEYS  = 64;
  localparam int SLOTS = 4;

  // predictor state
  logic [7:0]  cx_tab [KEYS];
  logic [6:0]  cy_tab [KEYS];
  bit          lit_tab [KEYS];
  bit          ring_on [SLOTS];
  logic [31:0] ring_t0 [SLOTS];
  logic [8:0]  ring_hue [SLOTS];
  logic [5:0]  ring_key [SLOTS];
  logic [8:0]  hue_acc;
  logic [6:0]  layout_keys;

  rsp_t key_items [$];
  int   errors = 0;

  function automatic int unsigned eff_keys();
    return (layout_keys > KEYS) ? KEYS : layout_keys;
  endfunction

  function automatic int unsigned gap(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // new ripple: first free slot, else the one started longest ago
  task automatic claim_ring(input logic [5:0] key, input logic [31:0] now);
    int pick;
    pick = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!ring_on[i]) begin
        pick = i;
        break;
      end
      if (32'(now - ring_t0[i]) > 32'(now - ring_t0[pick])) pick = i;
    end
    ring_t0[pick]  = now;
    ring_hue[pick] = hue_acc;
    ring_key[pick] = key;
    ring_on[pick]  = 1'b1;
    hue_acc = 9'((int'(hue_acc) + int'(HUE_STEP)) % 360);
  endtask

  // one frame: an item per key of the layout
  task automatic render(input logic [31:0] now);
    rsp_t        frame [$];
    rsp_t        item;
    bit          live;
    int unsigned cnt, radius, ring_dist, delta, power, best, hue, dx, dy, hi, lo;
    logic [31:0] elapsed;
    live = 1'b0;
    cnt  = eff_keys();
    for (int k = 0; k < cnt; k++) begin
      best = 0;
      hue  = 0;
      for (int s = 0; s < SLOTS; s++) begin
        if (!ring_on[s]) continue;
        elapsed = now - ring_t0[s];
        radius  = 32'(elapsed * 32'd240) / 900;
        if (radius > 266) begin
          ring_on[s] = 1'b0;
          continue;
        end
        live = 1'b1;
        dx = gap(cx_tab[ring_key[s]], cx_tab[k]);
        dy = gap(cy_tab[ring_key[s]], cy_tab[k]);
        hi = (dx > dy) ? dx : dy;
        lo = (dx > dy) ? dy : dx;
        ring_dist = hi + lo / 2;
        delta     = gap(ring_dist, radius);
        if (delta >= 26) continue;
        power = 100 - delta * 100 / 26;
        if (power > best) begin
          best = power;
          hue  = (ring_hue[s] + ring_dist * 2) % 360;
        end
      end
      item = '0;
      item.out_key = 6'(k);
      if (best == 0) begin
        if (lit_tab[k]) begin
          item.action  = ACT_RESTORE;
          item.opacity = IDLE_OPACITY;
          lit_tab[k]   = 1'b0;
        end else begin
          item.action = ACT_NONE;
        end
      end else begin
        item.action  = ACT_SHOW;
        item.hue     = 9'(hue);
        item.opacity = 8'(153 + best * 102 / 100);
        lit_tab[k]   = 1'b1;
      end
      item.last = (k + 1 == cnt);
      frame.push_back(item);
    end
    foreach (frame[i]) begin
      frame[i].frame_live = live;
      key_items.push_back(frame[i]);
    end
  endtask

  task automatic report(input string what, input rsp_t exp_v, input rsp_t got);
    errors++;
    if (errors <= 10)
      $display({"mismatch %s: expected key %0d act %0d hue %0d op %0d live %0d last %0d,",
                " got key %0d act %0d hue %0d op %0d live %0d last %0d"},
               what, exp_v.out_key, exp_v.action, exp_v.hue, exp_v.opacity,
               exp_v.frame_live, exp_v.last, got.out_key, got.action, got.hue,
               got.opacity, got.frame_live, got.last);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      foreach (lit_tab[i]) lit_tab[i] = 1'b0;
      foreach (ring_on[i]) begin
        ring_on[i]  = 1'b0;
        ring_t0[i]  = '0;
        ring_hue[i] = '0;
        ring_key[i] = '0;
      end
      hue_acc     = '0;
      layout_keys = '0;
      key_items.delete();
    end else begin
      if (cfg_we) layout_keys = cfg_wdata;
      // request side
      if (req_valid && req_ready) begin
        case (req.command)
          CMD_LOAD: begin
            cx_tab[req.key_sel]  = req.pos_x;
            cy_tab[req.key_sel]  = req.pos_y;
            lit_tab[req.key_sel] = 1'b0;
          end
          CMD_PRESS: begin
            if (req.key_sel < eff_keys()) begin
              claim_ring(req.key_sel, req.now_ms);
              render(req.now_ms);
            end
          end
          CMD_TICK: render(req.now_ms);
          default: ;
        endcase
      end
      // response side
      if (rsp_valid && rsp_ready) begin
        if (key_items.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected response item key %0d", rsp.out_key);
        end else begin
          want = key_items.pop_front();
          if (rsp.out_key !== want.out_key) report("out_key", want, rsp);
          else if (rsp.action !== want.action) report("action", want, rsp);
          else if (rsp.hue !== want.hue) report("hue", want, rsp);
          else if (rsp.opacity !== want.opacity) report("opacity", want, rsp);
          else if (rsp.frame_live !== want.frame_live) report("frame_live", want, rsp);
          else if (rsp.last !== want.last) report("last", want, rsp);
        end
      end
    end
    pending    <= key_items.size();
    fail_count <= errors;
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives loads, presses and ticks into the ripple engine across several
// layout sizes, with random gaps and response stalls; the checker predicts
// and compares every frame item.
// ----------------------------------------------------------------------------
module testbench;
  import krle_pkg::*;

  localparam int CYCLE_LIMIT = 1200000;
  localparam int SETTLE      = 2000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  int               fail_count, pending;
  int               cycles = 0;
  bit               steady = 1'b0;   // no idling on either side
  logic [31:0]      clock_ms = 32'd1000;
  int               layout = 0;

  key_ripple_light_engine_core DUT (
    .clk, .rst, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
    .cfg_we, .cfg_wdata
  );

  krle_checker u_checker (
    .clk, .rst, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
    .cfg_we, .cfg_wdata, .fail_count, .pending
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // response stalls
  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(0, 99) >= 21);
  end

  task automatic send_item(input logic [1:0] cmd, input logic [5:0] key,
                           input logic [7:0] x, input logic [6:0] y,
                           input logic [31:0] now);
    req_valid   <= 1'b1;
    req.command <= cmd;
    req.key_sel <= key;
    req.pos_x   <= x;
    req.pos_y   <= y;
    req.now_ms  <= now;
    do @(posedge clk); while (!req_ready);
    if (!steady && $urandom_range(0, 99) < 21) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // register writes only while quiet
  task automatic set_layout(input int n);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(n);
    @(posedge clk);
    cfg_we    <= 1'b0;
    layout = (n > 64) ? 64 : n;
  endtask

  task automatic load_all();
    for (int k = 0; k < 64; k++)
      send_item(CMD_LOAD, 6'(k), 8'($urandom_range(0, 239)), 7'($urandom_range(0, 69)),
                clock_ms);
  endtask

  // mostly presses and ticks close in time so rings overlap keys
  task automatic random_items(input int n);
    int          pick;
    logic [1:0]  cmd;
    logic [5:0]  key;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) clock_ms = clock_ms + $urandom;           // far jump
      else if (pick < 6) clock_ms = clock_ms - $urandom_range(0, 500);
      else clock_ms = clock_ms + $urandom_range(0, 80);
      pick = $urandom_range(0, 99);
      if (pick < 12) cmd = CMD_LOAD;
      else if (pick < 50) cmd = CMD_PRESS;
      else if (pick < 96) cmd = CMD_TICK;
      else cmd = 2'd3;
      if (cmd == CMD_PRESS && layout > 0 && $urandom_range(0, 9) != 0)
        key = 6'($urandom_range(0, layout - 1));
      else
        key = 6'($urandom_range(0, 63));
      send_item(cmd, key, 8'($urandom_range(0, 239)), 7'($urandom_range(0, 69)), clock_ms);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full layout, extremes of coordinates and time
    set_layout(64);
    load_all();
    send_item(CMD_LOAD, 6'd0, 8'd0, 7'd0, clock_ms);
    send_item(CMD_LOAD, 6'd63, 8'd239, 7'd69, clock_ms);
    send_item(CMD_PRESS, 6'd0, 8'd0, 7'd0, 32'd1000);
    send_item(CMD_TICK, 6'd0, 8'd0, 7'd0, 32'd1300);
    send_item(CMD_PRESS, 6'd63, 8'd0, 7'd0, 32'd1400);
    send_item(CMD_TICK, 6'd0, 8'd0, 7'd0, 32'd1700);
    send_item(CMD_PRESS, 6'd10, 8'd0, 7'd0, 32'd1710);
    send_item(CMD_PRESS, 6'd20, 8'd0, 7'd0, 32'd1720);
    send_item(CMD_PRESS, 6'd30, 8'd0, 7'd0, 32'd1730);   // every slot taken: oldest reused
    send_item(2'd3, 6'd5, 8'd0, 7'd0, 32'd1740);
    send_item(CMD_TICK, 6'd0, 8'd0, 7'd0, 32'd2100);
    send_item(CMD_TICK, 6'd0, 8'd0, 7'd0, 32'd3200);     // rings expire
    send_item(CMD_PRESS, 6'd40, 8'd0, 7'd0, 32'hFFFF_FF00);
    send_item(CMD_TICK, 6'd0, 8'd0, 7'd0, 32'h0000_0050);   // time wraps
    send_item(CMD_TICK, 6'd0, 8'd0, 7'd0, 32'h8000_0000);   // product overflows
    clock_ms = 32'hFFFF_FE00;

    // random phases over several layout sizes
    random_items(50);
    steady = 1'b1;
    random_items(35);
    steady = 1'b0;
    drain();                                  // hold off until all frames seen
    random_items(30);
    set_layout(0);
    send_item(CMD_TICK, 6'd0, 8'd0, 7'd0, clock_ms);
    send_item(CMD_PRESS, 6'd0, 8'd0, 7'd0, clock_ms);
    random_items(15);
    set_layout(1);
    random_items(40);
    set_layout(13);
    send_item(CMD_PRESS, 6'd40, 8'd0, 7'd0, clock_ms);   // outside the layout
    random_items(35);
    set_layout(127);
    random_items(35);
    set_layout(100);
    random_items(40);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
